// File: hw/rtl/afb_pkg.sv
// Shared types, constants and the exponential fraction table of the activation unit.
package afb_pkg;

  // Activation modes held in the mode register
  localparam logic [1:0] MODE_LOGISTIC = 2'd0;
  localparam logic [1:0] MODE_RELU     = 2'd1;
  localparam logic [1:0] MODE_LEAKY    = 2'd2;
  localparam logic [1:0] MODE_SOFTMAX  = 2'd3;

  // Configuration register indexes
  localparam logic REG_MODE    = 1'b0;
  localparam logic REG_ROW_LEN = 1'b1;

  localparam int unsigned ROW_MAX_DEF = 64;
  localparam logic [6:0]  ROW_LEN_RST = 7'd10;

  // Leaky slope 0.01 in Q0.16
  localparam logic [14:0] LEAK_Q16  = 15'd655;
  // Exponent arguments at or beyond this magnitude saturate
  localparam logic [16:0] EXP_LIMIT = 17'd3072;
  // Width of the shared divider
  localparam int unsigned DIV_W     = 50;

  // Work kinds decided by the front end
  typedef enum logic [2:0] {
    K_PASS,
    K_ZERO,
    K_LEAKY,
    K_LOGI_F,
    K_LOGI_B,
    K_SMAX
  } afb_kind_t;

  typedef struct packed {
    afb_kind_t          kind;
    logic signed [15:0] a;   // layer input x
    logic signed [15:0] b;   // operand: x or gradient
  } afb_cmd_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } afb_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } afb_div_rsp_t;

  // Unsigned 64-bit quotient by shift and subtract; elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = num;
    for (int i = 0; i < 64; i++) begin
      rem = {rem[63:0], quo[63]};
      quo = {quo[62:0], 1'b0};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // e^(f/256) in Q.32 by a truncating Taylor series; elaboration only
  function automatic logic [33:0] exp_frac_q32(input int unsigned f);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = 64'h1_0000_0000;
    term = sum;
    for (int unsigned n = 1; n <= 20; n++) begin
      term = udiv64(term * 64'(f), 64'd256 * 64'(n));
      sum  = sum + term;
    end
    return sum[33:0];
  endfunction

  typedef logic [255:0][33:0] exp_tab_t;

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t t;
    for (int unsigned i = 0; i < 256; i++) begin
      t[i] = exp_frac_q32(i);
    end
    return t;
  endfunction

  localparam exp_tab_t    EXP_TAB = build_exp_tab();
  localparam logic [33:0] EXP_E1  = exp_frac_q32(256);

endpackage

// File: hw/rtl/afb_front.sv
// Front end: accepts input transactions, classifies them and queues the work.
module afb_front import afb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [1:0]   mode,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,
  input  logic         in_tuser,
  output logic         q_valid,
  output afb_cmd_t     q_cmd,
  input  logic         q_pop
);

  afb_cmd_t   fifo_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  afb_cmd_t   cmd;
  logic signed [15:0] x, g;
  logic       x_pos;

  assign x         = $signed(in_tdata[15:0]);
  assign g         = $signed(in_tdata[31:16]);
  assign x_pos     = (x > 16'sd0);
  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_cmd     = fifo_r[rd_ptr_r];

  // Classify by direction, mode and sign of x
  always_comb begin
    cmd.a    = x;
    cmd.b    = g;
    cmd.kind = K_PASS;
    if (!in_tuser) begin
      cmd.b = x;
      unique case (mode)
        MODE_LOGISTIC: cmd.kind = K_LOGI_F;
        MODE_SOFTMAX:  cmd.kind = K_SMAX;
        MODE_RELU:     cmd.kind = x_pos ? K_PASS : K_ZERO;
        default:       cmd.kind = x_pos ? K_PASS : K_LEAKY;
      endcase
    end else begin
      unique case (mode)
        MODE_LOGISTIC: cmd.kind = K_LOGI_B;
        MODE_SOFTMAX:  cmd.kind = K_PASS;
        MODE_RELU:     cmd.kind = x_pos ? K_PASS : K_ZERO;
        default:       cmd.kind = x_pos ? K_PASS : K_LEAKY;
      endcase
    end
  end

  // Two-entry queue towards the back end
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cmd;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// File: hw/rtl/afb_div.sv
// Restoring divider, one quotient bit per cycle, shared by the back end.
module afb_div import afb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  afb_div_req_t req,
  output afb_div_rsp_t rsp
);

  localparam int unsigned CNT_W = $clog2(DIV_W);

  logic [DIV_W:0]   rem_r;
  logic [DIV_W-1:0] quo_r, den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DIV_W:0]   rem_sh;
  logic             fits;

  assign rem_sh   = {rem_r[DIV_W-1:0], quo_r[DIV_W-1]};
  assign fits     = (rem_sh >= {1'b0, den_r});
  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

  always_ff @(posedge clk) begin
    done_r <= 1'b0;
    if (!busy_r && req.start) begin
      rem_r <= '0;
      quo_r <= req.num;
      den_r <= req.den;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? (rem_sh - {1'b0, den_r}) : rem_sh;
      quo_r <= {quo_r[DIV_W-2:0], fits};
      cnt_r <= cnt_r + 1'b1;
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (!busy_r && req.start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == CNT_W'(DIV_W - 1)) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

endmodule

// File: hw/rtl/afb_back.sv
// Back end: exponential, divides, products, softmax row store and output register.
module afb_back import afb_pkg::*; #(
  parameter int unsigned ROW_MAX = ROW_MAX_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [6:0]   row_length,
  input  logic         q_valid,
  input  afb_cmd_t     q_cmd,
  output logic         q_pop,
  output afb_div_req_t div_req,
  input  afb_div_rsp_t div_rsp,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [15:0]  out_tdata,
  output logic         out_tlast
);

  localparam int unsigned AW = $clog2(ROW_MAX);
  localparam int unsigned CW = $clog2(ROW_MAX + 1);
  localparam int unsigned LW = (CW > 7) ? CW : 7;

  typedef enum logic [3:0] {
    S_IDLE, S_EXPMUL, S_EXPDIV, S_EXPOK, S_LDIV, S_LB1, S_MUL, S_ROUND,
    S_EMIT, S_SMRD, S_SMDIV, S_SMWAIT, S_SMEMIT
  } state_t;

  state_t             state_r;
  afb_cmd_t           cmd_r;
  logic [49:0]        r_r;
  logic [83:0]        acc_r;
  logic [1:0]         dig_r;
  logic [3:0]         k_r;
  logic               neg_r;
  logic [31:0]        e_r;
  logic [8:0]         s_r;
  logic signed [15:0] op_r;
  logic [14:0]        mult_r;
  logic signed [31:0] prod_r;
  logic [15:0]        res_r;
  logic [CW-1:0]      cnt_r, idx_r;
  logic [39:0]        sum_r;
  logic [31:0]        rd_r;
  logic [31:0]        mem [ROW_MAX];
  afb_div_req_t       div_req_r;
  logic               out_tvalid_r, out_tlast_r;
  logic [15:0]        out_tdata_r;

  logic               out_free;
  logic signed [16:0] v17;
  logic               v_neg;
  logic [16:0]        u17;
  logic [63:0]        r_pad;
  logic [15:0]        digit;
  logic [49:0]        part;
  logic [83:0]        acc_nxt;
  logic [33:0]        p_hi;
  logic [32:0]        d_log;
  logic [40:0]        sum_add;
  logic [39:0]        sum_nxt;
  logic [CW-1:0]      cnt_nxt;
  logic               store_ok, row_end;
  logic signed [31:0] rnd;

  assign out_free   = !out_tvalid_r || out_tready;
  assign q_pop      = (state_r == S_IDLE) && q_valid;
  assign div_req    = div_req_r;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  // Exponent argument: x for softmax, -x for the logistic
  always_comb begin
    v17   = (q_cmd.kind == K_SMAX) ? 17'(q_cmd.a) : -17'(q_cmd.a);
    v_neg = v17[16];
    u17   = v_neg ? 17'(-v17) : 17'(v17);
  end

  // One 16-bit digit of r times e per cycle
  assign r_pad   = {14'd0, r_r};
  assign digit   = r_pad[{dig_r, 4'd0} +: 16];
  assign part    = digit * EXP_E1;
  assign acc_nxt = acc_r + ({34'd0, part} << {dig_r, 4'd0});
  assign p_hi    = r_r[49:16];

  assign d_log   = 33'h1_0000 + {1'b0, e_r};

  // Row bookkeeping
  assign store_ok = (cnt_r < CW'(ROW_MAX));
  assign cnt_nxt  = store_ok ? cnt_r + 1'b1 : cnt_r;
  assign sum_add  = {1'b0, sum_r} + {9'd0, e_r};
  assign sum_nxt  = !store_ok ? sum_r : (sum_add[40] ? '1 : sum_add[39:0]);
  assign row_end  = (LW'(cnt_nxt) >= LW'(row_length)) || (cnt_nxt == CW'(ROW_MAX));

  // Products stay well inside 16 bits after rounding, no clamp needed
  assign rnd = prod_r + 32'sd32768;

  // Row store: written with each softmax exp, read back for the row output
  always_ff @(posedge clk) begin
    if (state_r == S_EXPOK && cmd_r.kind == K_SMAX && store_ok) begin
      mem[cnt_r[AW-1:0]] <= e_r;
    end
    if (state_r == S_SMRD) begin
      rd_r <= mem[idx_r[AW-1:0]];
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    div_req_r.start <= 1'b0;
    if (out_tvalid_r && out_tready) out_tvalid_r <= 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          cmd_r <= q_cmd;
          unique case (q_cmd.kind)
            K_PASS: begin
              res_r   <= q_cmd.b;
              state_r <= S_EMIT;
            end
            K_ZERO: begin
              res_r   <= '0;
              state_r <= S_EMIT;
            end
            K_LEAKY: begin
              op_r    <= q_cmd.b;
              mult_r  <= LEAK_Q16;
              state_r <= S_MUL;
            end
            default: begin
              neg_r <= v_neg;
              if (u17 >= EXP_LIMIT) begin
                e_r     <= v_neg ? 32'd0 : 32'hFFFF_FFFF;
                state_r <= S_EXPOK;
              end else begin
                r_r     <= 50'(EXP_TAB[u17[7:0]]);
                k_r     <= u17[11:8];
                dig_r   <= '0;
                acc_r   <= '0;
                state_r <= S_EXPMUL;
              end
            end
          endcase
        end
      end
      S_EXPMUL: begin
        if (k_r == 4'd0) begin
          if (!neg_r) begin
            e_r     <= (p_hi[33:32] != 2'd0) ? 32'hFFFF_FFFF : p_hi[31:0];
            state_r <= S_EXPOK;
          end else begin
            div_req_r.start <= 1'b1;
            div_req_r.num   <= 50'(64'h1_0000_0000_0000);
            div_req_r.den   <= r_r;
            state_r         <= S_EXPDIV;
          end
        end else begin
          dig_r <= dig_r + 1'b1;
          if (dig_r == 2'd3) begin
            r_r   <= acc_nxt[81:32];
            acc_r <= '0;
            k_r   <= k_r - 1'b1;
          end else begin
            acc_r <= acc_nxt;
          end
        end
      end
      S_EXPDIV: begin
        if (div_rsp.done) begin
          e_r     <= div_rsp.quot[31:0];
          state_r <= S_EXPOK;
        end
      end
      S_EXPOK: begin
        if (cmd_r.kind == K_SMAX) begin
          cnt_r <= cnt_nxt;
          sum_r <= sum_nxt;
          idx_r <= '0;
          state_r <= row_end ? S_SMRD : S_IDLE;
        end else begin
          div_req_r.start <= 1'b1;
          div_req_r.num   <= 50'(32'h0100_0000) + {18'd0, d_log[32:1]};
          div_req_r.den   <= {17'd0, d_log};
          state_r         <= S_LDIV;
        end
      end
      S_LDIV: begin
        if (div_rsp.done) begin
          s_r <= div_rsp.quot[8:0];
          if (cmd_r.kind == K_LOGI_F) begin
            res_r   <= {7'd0, div_rsp.quot[8:0]};
            state_r <= S_EMIT;
          end else begin
            state_r <= S_LB1;
          end
        end
      end
      S_LB1: begin
        mult_r  <= 15'({6'd0, s_r} * (15'd256 - {6'd0, s_r}));
        op_r    <= cmd_r.b;
        state_r <= S_MUL;
      end
      S_MUL: begin
        prod_r  <= op_r * $signed({1'b0, mult_r});
        state_r <= S_ROUND;
      end
      S_ROUND: begin
        res_r   <= rnd[31:16];
        state_r <= S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_tvalid_r <= 1'b1;
          out_tdata_r  <= res_r;
          out_tlast_r  <= 1'b1;
          state_r      <= S_IDLE;
        end
      end
      S_SMRD: begin
        state_r <= S_SMDIV;
      end
      S_SMDIV: begin
        if (sum_r == 40'd0) begin
          res_r   <= '0;
          state_r <= S_SMEMIT;
        end else begin
          div_req_r.start <= 1'b1;
          div_req_r.num   <= {10'd0, rd_r, 8'd0} + {11'd0, sum_r[39:1]};
          div_req_r.den   <= {10'd0, sum_r};
          state_r         <= S_SMWAIT;
        end
      end
      S_SMWAIT: begin
        if (div_rsp.done) begin
          res_r   <= (div_rsp.quot > 50'd32767) ? 16'h7FFF : div_rsp.quot[15:0];
          state_r <= S_SMEMIT;
        end
      end
      S_SMEMIT: begin
        if (out_free) begin
          out_tvalid_r <= 1'b1;
          out_tdata_r  <= res_r;
          out_tlast_r  <= (idx_r + 1'b1 == cnt_r);
          if (idx_r + 1'b1 == cnt_r) begin
            cnt_r   <= '0;
            sum_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_SMRD;
          end
        end
      end
      default: state_r <= S_IDLE;
    endcase
    if (!rst_n) begin
      state_r         <= S_IDLE;
      cnt_r           <= '0;
      sum_r           <= '0;
      out_tvalid_r    <= 1'b0;
      div_req_r.start <= 1'b0;
    end
  end

endmodule

// File: hw/rtl/activation_forward_backward.sv
// Top level of the activation unit: configuration registers and the front/back split.
//
// Usage: input transactions arrive on in_* (tdata = value, gradient; tuser = func,
// 0 forward, 1 backward). Results leave on out_* (tdata = result, tlast set on
// every single result and on the last element of a softmax row). The cfg port
// writes the mode (index 0) and the softmax row length (index 1) while idle.
// A front end classifies each item and queues it (two entries) for the back
// end, which owns the arithmetic and a registered output, so the input side
// keeps flowing while a result waits on a stalled receiver.
// Pass and zero items go straight to the output; leaky items take a multiply and
// a rounding step. The logistic runs one pass of the exp digit multiply per integer
// unit of |x|, then a divide; backward adds a product, and a negative exponent
// adds a divide. Softmax items store their exp; the row end divides each by the
// row sum. The 50-bit one-bit-per-cycle divider and the exp loop set item times.
// Reset (synchronous, rst_n low) empties the queue, clears row count and sum,
// drops out_tvalid and restores mode 0 and row length 10. The row store needs
// no clearing. A stalled receiver holds the result; the queue then fills and
// in_tready falls.
module activation_forward_backward import afb_pkg::*; #(
  parameter int unsigned ROW_MAX = ROW_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] value, [31:16] gradient
  input  logic        in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] result
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_wdata
);

  logic [1:0]   mode_r;
  logic [6:0]   row_len_r;
  logic         q_valid, q_pop;
  afb_cmd_t     q_cmd;
  afb_div_req_t div_req;
  afb_div_rsp_t div_rsp;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_LOGISTIC;
      row_len_r <= ROW_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:    mode_r    <= cfg_wdata[1:0];
        REG_ROW_LEN: row_len_r <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  afb_front u_front (
    .clk, .rst_n, .mode(mode_r),
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .q_valid, .q_cmd, .q_pop
  );

  afb_div u_div (.clk, .rst_n, .req(div_req), .rsp(div_rsp));

  afb_back #(.ROW_MAX(ROW_MAX)) u_back (
    .clk, .rst_n, .row_length(row_len_r),
    .q_valid, .q_cmd, .q_pop, .div_req, .div_rsp,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

endmodule

// File: hw/rtl/afb_checker.sv
// Port-level checks of the activation unit, bound to the top level.
module afb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Inner softmax elements are probabilities in Q8.8
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !out_tdata[15] && out_tdata <= 16'd256)
    else $error("softmax element out of range");

  // Reset drops the output
  a_rst_out: assert property (@(posedge clk) $past(!rst_n) |-> !out_tvalid)
    else $error("output valid after reset");

  // Reset empties the queue, so input is ready
  a_rst_in: assert property (@(posedge clk) $past(!rst_n) |-> in_tready)
    else $error("input not ready after reset");

endmodule

bind activation_forward_backward afb_checker u_afb_checker (.*);

// File: dv/afb_result_checker.sv
// Result checker for the activation unit: watches the channels, predicts and compares.
module afb_result_checker import afb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_wdata,
  output int          fail_count,
  output int          results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] res;
    logic        last;
  } act_result_t;

  act_result_t  awaited_results[$];

  // Predictor state
  logic [1:0]        mode_q;
  logic [6:0]        row_len_q;
  longint unsigned   exp_row[64];
  longint unsigned   exp_sum;
  int unsigned       row_fill;

  localparam longint unsigned SUM_SAT = (64'd1 << 40) - 1;

  // e^(f/256) in Q.32, truncating series, f in 0..256
  function automatic longint unsigned exp_fraction(int unsigned f);
    longint unsigned acc, term;
    acc  = 64'd1 << 32;
    term = acc;
    for (int unsigned n = 1; n <= 20; n++) begin
      term = term * f / (64'd256 * n);
      acc  = acc + term;
    end
    return acc;
  endfunction

  function automatic longint unsigned exp_positive(int unsigned u);
    logic [127:0]    prod;
    longint unsigned r, e1;
    r  = exp_fraction(u & 255);
    e1 = exp_fraction(256);
    for (int unsigned k = u >> 8; k > 0; k--) begin
      prod = 128'(r) * 128'(e1);
      r    = prod[95:32];
    end
    return r;
  endfunction

  // e^(v/256) in Q16.16, saturating
  function automatic longint unsigned exp_q16(int v);
    longint unsigned p;
    if (v >= 0) begin
      if (v >= 3072) return 64'hFFFF_FFFF;
      p = exp_positive(v) >> 16;
      return (p > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : p;
    end
    if (-v >= 3072) return 0;
    return (64'd1 << 48) / exp_positive(-v);
  endfunction

  function automatic longint sigmoid_q8(int x);
    longint unsigned den;
    den = 65536 + exp_q16(-x);
    return longint'(((64'd1 << 24) + den / 2) / den);
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // Round to nearest, ties up, dropping 16 fraction bits
  function automatic longint round16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  // Expected results of one accepted transaction
  task automatic predict_item(logic func, logic signed [15:0] x, logic signed [15:0] g);
    longint      s;
    logic [15:0] r;
    int unsigned eff_len;
    longint unsigned q;
    if (!func && mode_q == MODE_SOFTMAX) begin
      eff_len = (row_len_q == 0) ? 1 : (row_len_q > 64) ? 64 : row_len_q;
      if (row_fill < 64) begin
        exp_row[row_fill] = exp_q16(x);
        exp_sum = exp_sum + exp_row[row_fill];
        if (exp_sum > SUM_SAT) exp_sum = SUM_SAT;
        row_fill++;
      end
      if (row_fill < eff_len) return;
      for (int unsigned k = 0; k < row_fill; k++) begin
        q = (exp_sum == 0) ? 0 : (exp_row[k] * 256 + exp_sum / 2) / exp_sum;
        awaited_results.push_back('{clamp16(longint'(q)), k + 1 == row_fill});
      end
      row_fill = 0;
      exp_sum  = 0;
      return;
    end
    if (!func) begin
      if (mode_q == MODE_LOGISTIC) r = clamp16(sigmoid_q8(x));
      else if (x > 0)              r = x;
      else if (mode_q == MODE_RELU) r = '0;
      else                         r = clamp16(round16(longint'(x) * 655));
    end else begin
      if (mode_q == MODE_LOGISTIC) begin
        s = sigmoid_q8(x);
        r = clamp16(round16(longint'(g) * s * (256 - s)));
      end else if (mode_q == MODE_SOFTMAX || x > 0) r = g;
      else if (mode_q == MODE_RELU) r = '0;
      else r = clamp16(round16(longint'(g) * 655));
    end
    awaited_results.push_back('{r, 1'b1});
  endtask

  task automatic report_mismatch(string what);
    $display("%0t ns: error: %s", $realtime, what);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    act_result_t want;
    if (!rst_n) begin
      mode_q    <= MODE_LOGISTIC;
      row_len_q <= ROW_LEN_RST;
      row_fill  = 0;
      exp_sum   = 0;
      awaited_results.delete();
    end else begin
      // Configuration writes are expected only while idle; the checker does not enforce this
      if (cfg_we) begin
        if (cfg_index == REG_MODE) mode_q <= cfg_wdata[1:0];
        else                       row_len_q <= cfg_wdata;
      end
      if (in_tvalid && in_tready)
        predict_item(in_tuser, in_tdata[15:0], in_tdata[31:16]);
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h last %b", out_tdata, out_tlast));
        end else begin
          want = awaited_results.pop_front();
          if (out_tdata !== want.res)
            report_mismatch($sformatf("result %h, predicted %h", out_tdata, want.res));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("tlast %b, predicted %b", out_tlast, want.last));
        end
      end
    end
    results_pending = awaited_results.size();
  end
endmodule

// File: dv/activation_forward_backward_test.sv
// Testbench top for the activation unit: stimulus, receiver stalls and verdict.
module activation_forward_backward_test;
  import afb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [15:0] value, [31:16] gradient
  logic        in_tuser;   // [0] func
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [15:0] result
  logic        out_tlast;
  logic        cfg_we;
  logic        cfg_index;
  logic [6:0]  cfg_wdata;
  int          fail_count;
  int          results_pending;

  localparam logic FWD = 1'b0;
  localparam logic BWD = 1'b1;

  bit          long_hold_req;
  int          burst_left;

  activation_forward_backward DUT (.*);

  afb_result_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #20ms;
    $display("activation_forward_backward: mismatch");
    $finish;
  end

  // Receiver: alternating ready and random stall stretches, plus one long hold
  initial begin
    int hold_cnt, phase_cnt;
    bit stall_phase;
    out_tready = 1'b0;
    hold_cnt = 0;
    phase_cnt = 0;
    stall_phase = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_cnt = 600;
      end
      if (phase_cnt == 0) begin
        phase_cnt = $urandom_range(20, 120);
        stall_phase = ~stall_phase;
      end
      phase_cnt--;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= stall_phase ? ($urandom_range(0, 2) != 0) : 1'b1;
      end
    end
  end

  // One input transaction, with bursty gaps in front
  task automatic send_item(logic func, logic [15:0] x, logic [15:0] g);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {g, x};
    forever begin
      @(negedge clk);
      if (in_tready) break;
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (results_pending != 0) @(negedge clk);
  endtask

  // Register write once idle; softmax items may still be in flight
  task automatic write_reg(logic idx, logic [6:0] data);
    drain();
    repeat (400) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 16'(16'h8000 + $urandom_range(0, 3));
      1:       return 16'(16'h7FFF - $urandom_range(0, 3));
      2, 3:    return 16'($signed($urandom_range(0, 4000)) - 2000);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [1:0] mode;
    logic [6:0] len;
    int n;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = FWD;
    cfg_we = 1'b0;
    cfg_index = REG_MODE;
    cfg_wdata = '0;
    long_hold_req = 1'b0;
    burst_left = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: logistic from reset, extremes both ways
    send_item(FWD, 16'h7FFF, 16'h0000);
    send_item(FWD, 16'h8000, 16'h0000);
    send_item(FWD, 16'h0000, 16'h0000);
    send_item(BWD, 16'h0000, 16'h7FFF);
    send_item(BWD, 16'hFF00, 16'h8000);
    // ReLU
    write_reg(REG_MODE, 7'(MODE_RELU));
    send_item(FWD, 16'h8000, 16'h0000);
    send_item(FWD, 16'h7FFF, 16'h0000);
    send_item(BWD, 16'hFFFF, 16'h1234);
    send_item(BWD, 16'h0001, 16'h8000);
    // Leaky
    write_reg(REG_MODE, 7'(MODE_LEAKY));
    send_item(FWD, 16'h8000, 16'h0000);
    send_item(FWD, 16'hFF80, 16'h0000);
    send_item(BWD, 16'h8000, 16'h8000);
    send_item(BWD, 16'hFFFF, 16'h7FFF);
    // Softmax: a zero-sum row, then a short row left partial across a mode change
    write_reg(REG_MODE, 7'(MODE_SOFTMAX));
    write_reg(REG_ROW_LEN, 7'd2);
    send_item(FWD, 16'h8000, 16'h0000);
    send_item(FWD, 16'hF000, 16'h0000);
    send_item(BWD, 16'h1111, 16'h8001);
    write_reg(REG_ROW_LEN, 7'd10);
    send_item(FWD, 16'h0100, 16'h0000);
    send_item(FWD, 16'h7FFF, 16'h0000);
    write_reg(REG_MODE, 7'(MODE_RELU));
    send_item(FWD, 16'h0200, 16'h0000);
    write_reg(REG_MODE, 7'(MODE_SOFTMAX));
    // Row length lowered mid-row, then out-of-range lengths
    write_reg(REG_ROW_LEN, 7'd1);
    send_item(FWD, 16'h0C00, 16'h0000);
    write_reg(REG_ROW_LEN, 7'd0);
    send_item(FWD, 16'hFE00, 16'h0000);
    write_reg(REG_ROW_LEN, 7'd127);
    for (int i = 0; i < 64; i++) send_item(FWD, 16'h7FFF, 16'h0000);

    // Receiver holds off while the sender keeps offering
    write_reg(REG_MODE, 7'(MODE_RELU));
    long_hold_req = 1'b1;
    for (int i = 0; i < 10; i++)
      send_item(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));

    // Random phases over mode and row length
    n = 0;
    while (n < 40) begin
      mode = 2'($urandom_range(0, 3));
      len  = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                         : 7'($urandom_range(1, 6));
      write_reg(REG_MODE, 7'(mode));
      write_reg(REG_ROW_LEN, len);
      for (int i = 0; i < 10; i++) begin
        send_item((mode == MODE_SOFTMAX) ? ($urandom_range(0, 4) == 0)
                                         : logic'($urandom_range(0, 1)),
                  pick_value(), pick_value());
        if ($urandom_range(0, 30) == 0) drain();
        n++;
      end
    end

    drain();
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("activation_forward_backward: match");
    end else begin
      $display("activation_forward_backward: mismatch");
    end
    $finish;
  end
endmodule
